>>> design/rbtf_pkg.sv
// Shared types, constants and arithmetic helpers for the range/bearing telegram formatter.
// Depends on nothing; every other design file imports it.
package rbtf_pkg;

   // Telegram format codes held in the format register.
   localparam logic [2:0] FMT_ASCII_CDEG = 3'd0;
   localparam logic [2:0] FMT_ASCII_MDEG = 3'd1;
   localparam logic [2:0] FMT_BCD_CDEG   = 3'd2;
   localparam logic [2:0] FMT_BCD_MDEG   = 3'd3;
   localparam logic [2:0] FMT_BCD_BEAR   = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_FORMAT = 2'd0;
   localparam logic [1:0] CSR_STATUS = 2'd1;

   // Characters and marks used in the telegrams.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] END_MARK   = 8'hFF;
   localparam logic [3:0] ASCII_HI   = 4'h3;

   // Telegram sizes.
   localparam int unsigned TELE_MAX_BYTES = 17;
   localparam logic [4:0]  LEN_ASCII_CDEG = 5'd16;
   localparam logic [4:0]  LEN_ASCII_MDEG = 5'd17;
   localparam logic [4:0]  LEN_BCD_SHORT  = 5'd7;
   localparam logic [4:0]  LEN_BCD_BEAR   = 5'd9;

   // Saturation limits and bearing turn.
   localparam logic [16:0] RANGE_M_MAX  = 17'd99999;
   localparam logic [19:0] RANGE_DM_MAX = 20'd999999;
   localparam logic [12:0] BEAR_TURN    = 13'd1800;
   localparam logic [12:0] BEAR_FULL    = 13'd3600;

   // Input and result words.
   typedef struct packed {
      logic [19:0] range_dm;
      logic [18:0] azimuth_mdeg;
      logic [11:0] bearing_ddeg;
      logic        station_found;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_word_type;

   // Six decimal digits; entry 0 is the most significant digit.
   typedef logic [5:0][3:0] digits_type;

   // A finished telegram; byte 0 goes out first.
   typedef struct packed {
      logic [TELE_MAX_BYTES-1:0][7:0] bytes;
      logic [4:0]                     len;
   } tele_type;

   // Register load strobes for the conversion stages.
   typedef struct packed {
      logic s2_load;
      logic s3_load;
      logic s4_load;
   } pipe_ctrl_type;

   // Divide by ten through the reciprocal; exact for every 21-bit value.
   function automatic logic [17:0] div10(input logic [20:0] x);
      logic [40:0] p;
      p = 41'(x) * 41'd838861;
      return p[40:23];
   endfunction

   // Divide by one thousand through the reciprocal; quotient below 1000 for lane values.
   function automatic logic [9:0] div1000(input logic [19:0] x);
      logic [40:0] p;
      p = 41'(x) * 41'd1073742;
      return p[39:30];
   endfunction

   // Hundreds digit of a value below 1000, found by parallel compares.
   function automatic logic [3:0] hund_digit(input logic [9:0] x);
      logic [3:0] d;
      d = '0;
      for (int k = 1; k < 10; k++) begin
         if (x >= 10'(k * 100)) begin
            d = 4'(k);
         end
      end
      return d;
   endfunction

   // Tens digit of a value below 100.
   function automatic logic [3:0] tens_digit(input logic [6:0] x);
      logic [3:0] d;
      d = '0;
      for (int k = 1; k < 10; k++) begin
         if (x >= 7'(k * 10)) begin
            d = 4'(k);
         end
      end
      return d;
   endfunction

endpackage

>>> design/rbtf_digits.sv
// Binary to six decimal digits for one value lane, over three register stages.
// Depends on rbtf_pkg for the divide helpers and the stage load strobes.
module rbtf_digits import rbtf_pkg::*; (
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  logic [19:0]   value,
   output digits_type    digits
);

   logic [19:0] v2_ff;
   logic [19:0] v3_ff;
   logic [9:0]  hi3_ff;
   logic [9:0]  lo3;
   logic [3:0]  dh_in;
   logic [3:0]  dl_in;
   logic [3:0]  dh4_ff;
   logic [3:0]  dl4_ff;
   logic [6:0]  rh4_ff;
   logic [6:0]  rl4_ff;
   logic [3:0]  th;
   logic [3:0]  tl;

   // Stage 2 holds the value; its quotient by one thousand is taken on the way out.
   always_ff @(posedge clock) begin
      if (ctrl.s2_load) begin
         v2_ff <= value;
      end
      if (ctrl.s3_load) begin
         v3_ff  <= v2_ff;
         hi3_ff <= div1000(v2_ff);
      end
   end

   // Stage 3 splits both three-digit halves into a hundreds digit and a remainder.
   always_comb begin
      lo3   = 10'(v3_ff - 20'(hi3_ff) * 20'd1000);
      dh_in = hund_digit(hi3_ff);
      dl_in = hund_digit(lo3);
   end

   always_ff @(posedge clock) begin
      if (ctrl.s4_load) begin
         dh4_ff <= dh_in;
         dl4_ff <= dl_in;
         rh4_ff <= 7'(hi3_ff - 10'(dh_in) * 10'd100);
         rl4_ff <= 7'(lo3 - 10'(dl_in) * 10'd100);
      end
   end

   // Stage 4 finishes the tens and ones digits.
   always_comb begin
      th = tens_digit(rh4_ff);
      tl = tens_digit(rl4_ff);
      digits[0] = dh4_ff;
      digits[1] = th;
      digits[2] = 4'(rh4_ff - 7'(th) * 7'd10);
      digits[3] = dl4_ff;
      digits[4] = tl;
      digits[5] = 4'(rl4_ff - 7'(tl) * 7'd10);
   end

endmodule

>>> design/rbtf_serializer.sv
// Telegram output buffer: takes a whole telegram and hands it out one byte word at a time.
// Depends on rbtf_pkg for the telegram and result word types.
module rbtf_serializer import rbtf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         tele_valid,
   input  tele_type     tele,
   output logic         tele_ready,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   logic [TELE_MAX_BYTES-1:0][7:0] bytes_ff;
   logic [4:0]                     left_ff;
   logic                           valid_ff;
   logic                           last;
   logic                           take;
   logic                           load;

   assign last       = (left_ff == 5'd1);
   assign take       = valid_ff && !rsp_stall;
   assign tele_ready = !valid_ff || (take && last);
   assign load       = tele_valid && tele_ready;

   // Control: the buffer is busy from load until its last word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff  <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         left_ff  <= tele.len;
      end else if (take) begin
         valid_ff <= !last;
         left_ff  <= left_ff - 5'd1;
      end
   end

   // Payload shifts down one byte per word taken.
   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= tele.bytes;
      end else if (take) begin
         bytes_ff <= {8'h00, bytes_ff[TELE_MAX_BYTES-1:1]};
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_data.out_byte  = bytes_ff[0];
   assign rsp_data.last_byte = last;

   // A busy buffer always has bytes left to send.
   a_busy_has_bytes: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> left_ff != 5'd0)
      else $error("telegram buffer busy with no bytes left");

   // A word taken that was not the last one leaves another word on offer.
   a_no_early_end: assert property (@(posedge clock) disable iff (reset)
      take && !last |=> valid_ff)
      else $error("telegram ended before its last byte");

endmodule

>>> design/range_bearing_telegram_formatter.sv
// Range/bearing position telegram formatter, top level.
// Depends on rbtf_pkg, rbtf_digits and rbtf_serializer.
//
// Each position word (range, azimuth, bearing, station flag) becomes one telegram of 16 or 17
// ASCII bytes (formats 0 and 1) or 7 or 9 packed BCD bytes (formats 2, 3 and 4), sent one
// byte word per cycle while the output is not stalled, with the last byte marked. From
// acceptance a word passes through one input register, three digit conversion stages and
// the output buffer before its first byte. The sustained rate is set by the single
// byte-wide output; up to four further words are held in the stages while a telegram drains.
// ASCII formats with no station, and unused format codes, produce no bytes. The configuration
// port is always ready; write it only while the block is empty.
module range_bearing_telegram_formatter import rbtf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   logic [2:0]    fmt_ff;
   logic          status_ff;
   req_word_type  req_ff;
   logic          s1_valid_ff;
   logic          s2_valid_ff;
   logic          s3_valid_ff;
   logic          s4_valid_ff;
   logic          found2_ff;
   logic          found3_ff;
   logic          found4_ff;
   logic          s1_keep;
   logic          s1_free;
   logic          s2_free;
   logic          s3_free;
   logic          s4_free;
   logic          req_accept;
   logic          ser_ready;
   pipe_ctrl_type ctrl;
   logic [17:0]   az_cdeg;
   logic [17:0]   range_q;
   logic [16:0]   range_m;
   logic [19:0]   dm_sat;
   logic [12:0]   bear_sum;
   logic [11:0]   bear_rot;
   logic [19:0]   lane_a;
   logic [19:0]   lane_r;
   logic [19:0]   lane_b;
   digits_type    dig_a;
   digits_type    dig_r;
   digits_type    dig_b;
   tele_type      tele;
   logic          is_ascii;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_ASCII_CDEG;
         status_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FORMAT: fmt_ff    <= csr_wdata[2:0];
            CSR_STATUS: status_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Flow control: a stage moves on when the next one is free or frees up this cycle.
   assign is_ascii  = (fmt_ff == FMT_ASCII_CDEG) || (fmt_ff == FMT_ASCII_MDEG);
   assign s1_keep   = (fmt_ff <= FMT_BCD_BEAR) && !(is_ascii && !req_ff.station_found);
   assign s4_free   = !s4_valid_ff || ser_ready;
   assign s3_free   = !s3_valid_ff || s4_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || !s1_keep || s2_free;
   assign req_stall = !s1_free;
   assign req_accept = req_valid && !req_stall;

   assign ctrl.s2_load = s1_valid_ff && s1_keep && s2_free;
   assign ctrl.s3_load = s2_valid_ff && s3_free;
   assign ctrl.s4_load = s3_valid_ff && s4_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_accept;
         end
         if (s2_free) begin
            s2_valid_ff <= ctrl.s2_load;
         end
         if (s3_free) begin
            s3_valid_ff <= ctrl.s3_load;
         end
         if (s4_free) begin
            s4_valid_ff <= ctrl.s4_load;
         end
      end
   end

   // Input register and the station flag that follows the word down the stages.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      if (ctrl.s2_load) begin
         found2_ff <= req_ff.station_found;
      end
      if (ctrl.s3_load) begin
         found3_ff <= found2_ff;
      end
      if (ctrl.s4_load) begin
         found4_ff <= found3_ff;
      end
   end

   // Stage 1 rescales: rounded centidegrees and metres, saturation, bearing turned half round.
   always_comb begin
      az_cdeg  = div10(21'(req_ff.azimuth_mdeg) + 21'd5);
      range_q  = div10(21'(req_ff.range_dm) + 21'd5);
      range_m  = (range_q > 18'(RANGE_M_MAX)) ? RANGE_M_MAX : range_q[16:0];
      dm_sat   = (req_ff.range_dm > RANGE_DM_MAX) ? RANGE_DM_MAX : req_ff.range_dm;
      bear_sum = 13'(req_ff.bearing_ddeg) + BEAR_TURN;
      bear_rot = (bear_sum >= BEAR_FULL) ? 12'(bear_sum - BEAR_FULL) : bear_sum[11:0];
      lane_a   = ((fmt_ff == FMT_ASCII_CDEG) || (fmt_ff == FMT_BCD_CDEG)) ?
                 20'(az_cdeg) : 20'(req_ff.azimuth_mdeg);
      lane_r   = ((fmt_ff == FMT_BCD_CDEG) || (fmt_ff == FMT_BCD_MDEG)) ?
                 20'(range_m) : dm_sat;
      lane_b   = 20'(bear_rot);
   end

   // Digit conversion, one lane each for azimuth, range and bearing.
   rbtf_digits u_digits_az (
      .clock  (clock),
      .ctrl   (ctrl),
      .value  (lane_a),
      .digits (dig_a)
   );

   rbtf_digits u_digits_range (
      .clock  (clock),
      .ctrl   (ctrl),
      .value  (lane_r),
      .digits (dig_r)
   );

   rbtf_digits u_digits_bear (
      .clock  (clock),
      .ctrl   (ctrl),
      .value  (lane_b),
      .digits (dig_b)
   );

   // Stage 4 lays the digits out as the selected telegram.
   always_comb begin
      tele.bytes = '0;
      tele.len   = '0;
      unique case (fmt_ff)
         FMT_ASCII_CDEG: begin
            for (int k = 0; k < 6; k++) begin
               tele.bytes[k] = {ASCII_HI, dig_r[k]};
            end
            tele.bytes[6] = CHAR_SPACE;
            for (int k = 0; k < 5; k++) begin
               tele.bytes[7 + k] = {ASCII_HI, dig_a[k + 1]};
            end
            tele.bytes[12] = CHAR_SPACE;
            tele.bytes[13] = {ASCII_HI, 3'b000, status_ff};
            tele.bytes[14] = CHAR_CR;
            tele.bytes[15] = CHAR_LF;
            tele.len       = LEN_ASCII_CDEG;
         end
         FMT_ASCII_MDEG: begin
            for (int k = 0; k < 6; k++) begin
               tele.bytes[k]     = {ASCII_HI, dig_r[k]};
               tele.bytes[7 + k] = {ASCII_HI, dig_a[k]};
            end
            tele.bytes[6]  = CHAR_SPACE;
            tele.bytes[13] = CHAR_SPACE;
            tele.bytes[14] = {ASCII_HI, 3'b000, status_ff};
            tele.bytes[15] = CHAR_CR;
            tele.bytes[16] = CHAR_LF;
            tele.len       = LEN_ASCII_MDEG;
         end
         FMT_BCD_CDEG, FMT_BCD_MDEG: begin
            if (fmt_ff == FMT_BCD_CDEG) begin
               tele.bytes[0] = {dig_a[1], dig_a[2]};
               tele.bytes[1] = {dig_a[3], dig_a[4]};
               tele.bytes[2] = {4'h0, dig_a[5]};
            end else begin
               tele.bytes[0] = {dig_a[0], dig_a[1]};
               tele.bytes[1] = {dig_a[2], dig_a[3]};
               tele.bytes[2] = {dig_a[4], dig_a[5]};
            end
            if (found4_ff) begin
               tele.bytes[3] = {dig_r[1], dig_r[2]};
               tele.bytes[4] = {dig_r[3], dig_r[4]};
               tele.bytes[5] = {4'h0, dig_r[5]};
               tele.bytes[6] = END_MARK;
            end
            tele.len = LEN_BCD_SHORT;
         end
         FMT_BCD_BEAR: begin
            tele.bytes[0] = {dig_a[0], dig_a[1]};
            tele.bytes[1] = {dig_a[2], dig_a[3]};
            tele.bytes[2] = {dig_a[4], dig_a[5]};
            if (found4_ff) begin
               tele.bytes[3] = {dig_r[0], dig_r[1]};
               tele.bytes[4] = {dig_r[2], dig_r[3]};
               tele.bytes[5] = {dig_r[4], dig_r[5]};
            end
            tele.bytes[6] = {dig_b[2], dig_b[3]};
            tele.bytes[7] = {dig_b[4], dig_b[5]};
            tele.bytes[8] = END_MARK;
            tele.len      = LEN_BCD_BEAR;
         end
         default: ;
      endcase
   end

   // Output buffer.
   rbtf_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .tele_valid (s4_valid_ff),
      .tele       (tele),
      .tele_ready (ser_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // An accepted word always lands in the input register.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted word lost at the input register");

   // A finished telegram waits while the output buffer is busy.
   a_tele_holds: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !ser_ready |=> s4_valid_ff)
      else $error("telegram dropped while output buffer busy");

   // Every telegram ends in a line feed, an end mark, or a blanked end mark.
   a_last_byte_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_byte |->
         rsp_data.out_byte == CHAR_LF || rsp_data.out_byte == END_MARK ||
         rsp_data.out_byte == 8'h00)
      else $error("telegram ends in an unexpected byte");

endmodule
